// ----- design/lpmv_pkg.sv -----
// Package for the lamp pattern mode voter.
// Holds sizes, class codes, lamp pattern constants and the vote unit control struct.
// Depends on nothing.
`timescale 1ns / 1ps

package lpmv_pkg;

	localparam int MODE_COUNT = 8;
	localparam int LAMP_COUNT = 16;
	localparam int MODE_W     = $clog2(MODE_COUNT);
	localparam int CNT_W      = 8;

	localparam logic [MODE_W-1:0] CLASS_BOOT    = 3'd0;
	localparam logic [MODE_W-1:0] CLASS_ATTRACT = 3'd1;
	localparam logic [MODE_W-1:0] CLASS_IDLE    = 3'd2;
	localparam logic [MODE_W-1:0] CLASS_ATTACK  = 3'd3;
	localparam logic [MODE_W-1:0] CLASS_TEST    = 3'd7;

	localparam logic [LAMP_COUNT-1:0] LIT_NONE  = 16'h0000;
	localparam logic [LAMP_COUNT-1:0] LIT_ALL   = 16'hffff;
	localparam logic [LAMP_COUNT-1:0] LIT_ALT_A = 16'hcccc;
	localparam logic [LAMP_COUNT-1:0] LIT_ALT_B = 16'h3333;
	localparam logic [LAMP_COUNT-1:0] LIT_ALT_C = 16'h6666;
	localparam logic [LAMP_COUNT-1:0] LIT_ALT_D = 16'h9999;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd64;

	typedef struct packed {
		logic              step;
		logic [MODE_W-1:0] sel;
	} vote_ctrl_t;

endpackage

// ----- design/lpmv_classify.sv -----
// Lamp pattern classifier for the mode voter.
// Inverts the active-low sample and maps the lit pattern to a class code.
// Depends on lpmv_pkg.
`timescale 1ns / 1ps

module lpmv_classify (
	input  logic [lpmv_pkg::LAMP_COUNT-1:0] lamp_lines,
	output logic [lpmv_pkg::MODE_W-1:0]     pattern_class
);
	import lpmv_pkg::*;

	logic [LAMP_COUNT-1:0] lit;
	logic                  single_lit;

	assign lit        = ~lamp_lines;
	assign single_lit = (lit != LIT_NONE) && ((lit & (lit - LAMP_COUNT'(1))) == LIT_NONE);

	always_comb begin
		if (lit == LIT_NONE) begin
			pattern_class = CLASS_IDLE;
		end else if (lit == LIT_ALL) begin
			pattern_class = CLASS_BOOT;
		end else if (lit == LIT_ALT_A || lit == LIT_ALT_B || lit == LIT_ALT_C
				|| lit == LIT_ALT_D) begin
			pattern_class = CLASS_ATTRACT;
		end else if (single_lit) begin
			pattern_class = CLASS_TEST;
		end else begin
			pattern_class = CLASS_ATTACK;
		end
	end

endmodule

// ----- design/lpmv_vote_unit.sv -----
// Vote counter bank with one shared read and saturating update port.
// The sequencer selects one counter per cycle and optionally writes back its update.
// Depends on lpmv_pkg.
`timescale 1ns / 1ps

module lpmv_vote_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpmv_pkg::vote_ctrl_t         ctrl,
	input  logic [lpmv_pkg::MODE_W-1:0]  cls,
	input  logic [lpmv_pkg::CNT_W-1:0]   limit,
	output logic [lpmv_pkg::CNT_W-1:0]   cnt,
	output logic [lpmv_pkg::CNT_W-1:0]   cnt_next
);
	import lpmv_pkg::*;

	logic [CNT_W-1:0] counters_q [MODE_COUNT];

	assign cnt = counters_q[ctrl.sel];

	always_comb begin
		cnt_next = cnt;
		if (ctrl.sel == cls) begin
			if (cnt < limit) begin
				cnt_next = cnt + CNT_W'(1);
			end
		end else if (cnt != '0) begin
			cnt_next = cnt - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MODE_COUNT; k++) begin
				counters_q[k] <= '0;
			end
		end else if (ctrl.step) begin
			counters_q[ctrl.sel] <= cnt_next;
		end
	end

endmodule

// ----- design/led_pattern_mode_voter.sv -----
// Top level of the lamp pattern mode voter.
// Holds the sequencer, the limit register and the result register.
// Depends on lpmv_pkg, lpmv_classify and lpmv_vote_unit.
`timescale 1ns / 1ps

// A request is accepted while the sequencer is idle. Its result becomes valid after
// the sequencer has passed through its load state, which fetches the counter of the
// current mode, its walk state, which walks the eight vote counters through the single
// read and update port of the counter bank, and its final state, which loads the result
// register. The load waits while the previous result has not been taken. The sequencer
// is idle again once the result is loaded, and no request is accepted before then. A new
// request is taken even while the previous result waits to be taken.

module led_pattern_mode_voter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         lamp_valid,
	output logic                         lamp_ready,
	input  logic [lpmv_pkg::LAMP_COUNT-1:0] lamp_lines,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [lpmv_pkg::MODE_W-1:0]  pattern_class,
	output logic [lpmv_pkg::MODE_W-1:0]  active_mode,
	output logic                         mode_changed,
	input  logic                         vote_limit_we,
	input  logic [lpmv_pkg::CNT_W-1:0]   vote_limit
);
	import lpmv_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [MODE_W-1:0] idx_q;
	logic [MODE_W-1:0] cls_q;
	logic [MODE_W-1:0] mode_q;
	logic [MODE_W-1:0] best_q;
	logic [CNT_W-1:0]  best_val_q;
	logic [CNT_W-1:0]  limit_q;
	logic              result_valid_q;
	logic [MODE_W-1:0] pattern_class_q;
	logic [MODE_W-1:0] active_mode_q;
	logic              mode_changed_q;

	logic [MODE_W-1:0] cls_in;
	vote_ctrl_t        ctrl;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  cnt_next;

	lpmv_classify u_classify (
		.lamp_lines    (lamp_lines),
		.pattern_class (cls_in)
	);

	always_comb begin
		ctrl.step = (state_q == ST_WALK);
		ctrl.sel  = (state_q == ST_WALK) ? idx_q : mode_q;
	end

	lpmv_vote_unit u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cls      (cls_q),
		.limit    (limit_q),
		.cnt      (cnt),
		.cnt_next (cnt_next)
	);

	assign lamp_ready    = (state_q == ST_IDLE);
	assign result_valid  = result_valid_q;
	assign pattern_class = pattern_class_q;
	assign active_mode   = active_mode_q;
	assign mode_changed  = mode_changed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (vote_limit_we) begin
			limit_q <= vote_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			mode_q         <= CLASS_BOOT;
			best_q         <= CLASS_BOOT;
			best_val_q     <= '0;
			cls_q          <= CLASS_BOOT;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (lamp_valid) begin
						cls_q   <= cls_in;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					best_q     <= mode_q;
					best_val_q <= cnt;
					idx_q      <= '0;
					state_q    <= ST_WALK;
				end
				ST_WALK: begin
					if (best_q == idx_q) begin
						best_val_q <= cnt_next;
					end else if (cnt_next > best_val_q) begin
						best_q     <= idx_q;
						best_val_q <= cnt_next;
					end
					if (idx_q == MODE_W'(MODE_COUNT - 1)) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + MODE_W'(1);
					end
				end
				ST_FIN: begin
					if (!result_valid_q || result_ready) begin
						pattern_class_q <= cls_q;
						active_mode_q   <= best_q;
						mode_changed_q  <= (best_q != mode_q);
						mode_q          <= best_q;
						result_valid_q  <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
